/* sv/assert_macros.svh */
// assertion macros shared by the ray/triangle test rtl
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle, off during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("ray triangle check failed");

// antecedent implies consequent in the next cycle, off during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("ray triangle check failed");

`endif

/* sv/rti_pkg.sv */
// constants and types for the ray/triangle intersection pipeline
// no dependencies
package rti_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int WORD_W     = 32;
	localparam int PROD_W     = 2 * WORD_W;
	localparam int SUM_W      = PROD_W - FRAC_BITS + 2;
	localparam int MAG_W      = SUM_W;
	localparam int QUO_W      = 31;
	localparam int DIST_W     = 31;
	localparam int BARY_W     = 17;
	localparam int EPS_W      = 16;
	localparam int AXIS_W     = 2;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int LATENCY    = QUO_W + 10;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_AXIS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NU     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NV     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ND     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_B = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_C = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_A = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_EPS    = 3'd7;

	// dominant axis codes
	localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
	localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
	localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

	localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

	// fields of the ray that ride along the pipeline
	typedef struct packed {
		logic signed [WORD_W-1:0] ou;
		logic signed [WORD_W-1:0] ov;
		logic signed [WORD_W-1:0] du;
		logic signed [WORD_W-1:0] dv;
		logic [DIST_W-1:0]        maxd;
	} ray_ctx_t;

	// one step of the restoring divider
	typedef struct packed {
		logic [MAG_W-1:0] rem;
		logic [MAG_W-1:0] den;
		logic [QUO_W-1:0] quo;
		logic [QUO_W-1:0] dvd;
		logic             sat;
		logic             neg;
		logic             zero;
		ray_ctx_t         ctx;
	} div_step_t;

endpackage

/* sv/ray_triangle_intersect.sv */
// ray against one configured triangle, projected-plane test, fixed point
// depends on rti_pkg and assert_macros.svh
`include "assert_macros.svh"

// Usage
//  A ray word is taken at each rising edge where start is high and busy is
//  low. busy never rises: one ray per cycle is accepted, without gaps.
//  Each ray gives exactly one result word, shown on hit, hit_dist,
//  bary_alpha and bary_beta for one cycle while done is high, in the order
//  the rays came in. Five front stages form the plane numerator and
//  denominator, a restoring divider of QUO_W (31 by default) quotient
//  bits spends one stage per bit, and five back stages project the hit
//  and form the barycentrics. Throughput is one ray per clock; the
//  divider is fully pipelined. The receiver cannot hold results off, so
//  nothing in the block waits. Triangle registers are written through
//  cfg_we, cfg_index, cfg_wdata; the user must do so only while no ray is
//  in flight, as the block does not enforce it. Reset clears all valid
//  bits, sets every triangle register to zero and the tolerance to 7.
module ray_triangle_intersect import rti_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [WORD_W-1:0]    origin_x,
	input  logic signed [WORD_W-1:0]    origin_y,
	input  logic signed [WORD_W-1:0]    origin_z,
	input  logic signed [WORD_W-1:0]    dir_x,
	input  logic signed [WORD_W-1:0]    dir_y,
	input  logic signed [WORD_W-1:0]    dir_z,
	input  logic [DIST_W-1:0]           max_dist,
	output logic                        done,
	output logic                        hit,
	output logic [DIST_W-1:0]           hit_dist,
	output logic [BARY_W-1:0]           bary_alpha,
	output logic [BARY_W-1:0]           bary_beta
);

	// triangle registers
	logic [AXIS_W-1:0]        axis_q;
	logic signed [WORD_W-1:0] nu_q, nv_q, nd_q;
	logic signed [WORD_W-1:0] bnu_q, bnv_q, cnu_q, cnv_q, au_q, av_q;
	logic [EPS_W-1:0]         eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= AXIS_X;
			nu_q   <= '0;
			nv_q   <= '0;
			nd_q   <= '0;
			bnu_q  <= '0;
			bnv_q  <= '0;
			cnu_q  <= '0;
			cnv_q  <= '0;
			au_q   <= '0;
			av_q   <= '0;
			eps_q  <= EPS_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_AXIS:   axis_q <= cfg_wdata[AXIS_W-1:0];
				REG_NU:     nu_q   <= cfg_wdata[WORD_W-1:0];
				REG_NV:     nv_q   <= cfg_wdata[WORD_W-1:0];
				REG_ND:     nd_q   <= cfg_wdata[WORD_W-1:0];
				REG_EDGE_B: begin
					bnu_q <= cfg_wdata[2*WORD_W-1:WORD_W];
					bnv_q <= cfg_wdata[WORD_W-1:0];
				end
				REG_EDGE_C: begin
					cnu_q <= cfg_wdata[2*WORD_W-1:WORD_W];
					cnv_q <= cfg_wdata[WORD_W-1:0];
				end
				REG_VERT_A: begin
					au_q <= cfg_wdata[2*WORD_W-1:WORD_W];
					av_q <= cfg_wdata[WORD_W-1:0];
				end
				REG_EPS:    eps_q  <= cfg_wdata[EPS_W-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;
	wire accept = start && !busy;

	// valid bits
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [QUO_W-1:0] div_vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			vld_s2     <= 1'b0;
			vld_s3     <= 1'b0;
			vld_s4     <= 1'b0;
			vld_s5     <= 1'b0;
			div_vld_s6 <= '0;
			vld_s7     <= 1'b0;
			vld_s8     <= 1'b0;
			vld_s9     <= 1'b0;
			vld_s10    <= 1'b0;
			vld_s11    <= 1'b0;
		end else begin
			vld_s1     <= accept;
			vld_s2     <= vld_s1;
			vld_s3     <= vld_s2;
			vld_s4     <= vld_s3;
			vld_s5     <= vld_s4;
			div_vld_s6 <= {div_vld_s6[QUO_W-2:0], vld_s5};
			vld_s7     <= div_vld_s6[QUO_W-1];
			vld_s8     <= vld_s7;
			vld_s9     <= vld_s8;
			vld_s10    <= vld_s9;
			vld_s11    <= vld_s10;
		end
	end

	// stage 1: pick dominant and projected axes
	logic signed [WORD_W-1:0] ok_s1, dk_s1;
	ray_ctx_t                 ctx_s1;

	always_ff @(posedge clk) begin
		ctx_s1.maxd <= max_dist;
		case (axis_q)
			AXIS_Y: begin
				ok_s1 <= origin_y; ctx_s1.ou <= origin_z; ctx_s1.ov <= origin_x;
				dk_s1 <= dir_y;    ctx_s1.du <= dir_z;    ctx_s1.dv <= dir_x;
			end
			AXIS_Z: begin
				ok_s1 <= origin_z; ctx_s1.ou <= origin_x; ctx_s1.ov <= origin_y;
				dk_s1 <= dir_z;    ctx_s1.du <= dir_x;    ctx_s1.dv <= dir_y;
			end
			default: begin
				ok_s1 <= origin_x; ctx_s1.ou <= origin_y; ctx_s1.ov <= origin_z;
				dk_s1 <= dir_x;    ctx_s1.du <= dir_y;    ctx_s1.dv <= dir_z;
			end
		endcase
	end

	// stage 2: plane products
	logic signed [PROD_W-1:0] p_nu_ou_s2, p_nv_ov_s2, p_nu_du_s2, p_nv_dv_s2;
	logic signed [WORD_W-1:0] ok_s2, dk_s2;
	ray_ctx_t                 ctx_s2;

	always_ff @(posedge clk) begin
		p_nu_ou_s2 <= nu_q * ctx_s1.ou;
		p_nv_ov_s2 <= nv_q * ctx_s1.ov;
		p_nu_du_s2 <= nu_q * ctx_s1.du;
		p_nv_dv_s2 <= nv_q * ctx_s1.dv;
		ok_s2      <= ok_s1;
		dk_s2      <= dk_s1;
		ctx_s2     <= ctx_s1;
	end

	// stage 3: numerator and denominator, products floored by the shift
	logic signed [SUM_W-1:0] num_s3, den_s3;
	ray_ctx_t                ctx_s3;

	always_ff @(posedge clk) begin
		num_s3 <= SUM_W'(nd_q) - SUM_W'(ok_s2)
			- SUM_W'(p_nu_ou_s2 >>> FRAC_BITS) - SUM_W'(p_nv_ov_s2 >>> FRAC_BITS);
		den_s3 <= SUM_W'(dk_s2)
			+ SUM_W'(p_nu_du_s2 >>> FRAC_BITS) + SUM_W'(p_nv_dv_s2 >>> FRAC_BITS);
		ctx_s3 <= ctx_s2;
	end

	// stage 4: sign and magnitudes
	logic [MAG_W-1:0] nmag_s4, dmag_s4;
	logic             neg_s4, zero_s4;
	ray_ctx_t         ctx_s4;

	always_ff @(posedge clk) begin
		nmag_s4 <= num_s3[SUM_W-1] ? MAG_W'(-num_s3) : MAG_W'(num_s3);
		dmag_s4 <= den_s3[SUM_W-1] ? MAG_W'(-den_s3) : MAG_W'(den_s3);
		neg_s4  <= num_s3[SUM_W-1] ^ den_s3[SUM_W-1];
		zero_s4 <= (den_s3 == '0);
		ctx_s4  <= ctx_s3;
	end

	// stage 5: divider setup, overflow when the integer quotient is too big
	div_step_t div_in_s5;
	logic [MAG_W-1:0] rem0;

	assign rem0 = nmag_s4 >> (QUO_W - FRAC_BITS);

	always_ff @(posedge clk) begin
		div_in_s5.rem  <= rem0;
		div_in_s5.den  <= dmag_s4;
		div_in_s5.quo  <= '0;
		div_in_s5.dvd  <= {nmag_s4[QUO_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
		div_in_s5.sat  <= (rem0 >= dmag_s4);
		div_in_s5.neg  <= neg_s4;
		div_in_s5.zero <= zero_s4;
		div_in_s5.ctx  <= ctx_s4;
	end

	// stage 6: restoring divider, one quotient bit per step
	div_step_t div_s6 [QUO_W];
	div_step_t div_nxt [QUO_W];

	always_comb begin
		div_step_t        src;
		logic [MAG_W:0]   shifted;
		logic             ge;
		for (int j = 0; j < QUO_W; j++) begin
			src = (j == 0) ? div_in_s5 : div_s6[(j == 0) ? 0 : j - 1];
			shifted = {src.rem, src.dvd[QUO_W-1]};
			ge = (shifted >= {1'b0, src.den});
			div_nxt[j]     = src;
			div_nxt[j].rem = ge ? MAG_W'(shifted - {1'b0, src.den}) : MAG_W'(shifted);
			div_nxt[j].quo = {src.quo[QUO_W-2:0], ge};
			div_nxt[j].dvd = {src.dvd[QUO_W-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < QUO_W; j++) begin
			div_s6[j] <= div_nxt[j];
		end
	end

	// stage 7: signed, saturated distance
	div_step_t                div_out;
	logic [QUO_W-1:0]         mag;
	logic signed [WORD_W-1:0] t_s7;
	logic                     zero_s7;
	ray_ctx_t                 ctx_s7;

	assign div_out = div_s6[QUO_W-1];
	assign mag     = div_out.sat ? {QUO_W{1'b1}} : div_out.quo;

	always_ff @(posedge clk) begin
		t_s7    <= div_out.neg ? -WORD_W'(mag) : WORD_W'(mag);
		zero_s7 <= div_out.zero;
		ctx_s7  <= div_out.ctx;
	end

	// stage 8: range check and hit point products
	logic [WORD_W-1:0]        far_lim;
	logic signed [PROD_W-1:0] p_tu_s8, p_tv_s8;
	logic signed [WORD_W-1:0] t_s8;
	logic                     miss_s8;
	ray_ctx_t                 ctx_s8;

	assign far_lim = WORD_W'(ctx_s7.maxd) + WORD_W'(eps_q);

	always_ff @(posedge clk) begin
		p_tu_s8 <= t_s7 * ctx_s7.du;
		p_tv_s8 <= t_s7 * ctx_s7.dv;
		miss_s8 <= zero_s7
			|| ((WORD_W+2)'(t_s7) > $signed({2'b00, far_lim}))
			|| (t_s7 < $signed({{(WORD_W-EPS_W){1'b0}}, eps_q}));
		t_s8    <= t_s7;
		ctx_s8  <= ctx_s7;
	end

	// stage 9: offsets from the first vertex, clamped to a word
	logic signed [SUM_W:0]    hu_w, hv_w;
	logic signed [WORD_W-1:0] hu_s9, hv_s9, t_s9;
	logic                     miss_s9;
	logic [DIST_W-1:0]        maxd_s9;

	localparam logic signed [SUM_W:0] W_MAX = (SUM_W+1)'(2147483647);
	localparam logic signed [SUM_W:0] W_MIN = -(SUM_W+1)'(64'sd2147483648);

	assign hu_w = (SUM_W+1)'(ctx_s8.ou) + (SUM_W+1)'(p_tu_s8 >>> FRAC_BITS)
		- (SUM_W+1)'(au_q);
	assign hv_w = (SUM_W+1)'(ctx_s8.ov) + (SUM_W+1)'(p_tv_s8 >>> FRAC_BITS)
		- (SUM_W+1)'(av_q);

	always_ff @(posedge clk) begin
		hu_s9   <= (hu_w > W_MAX) ? WORD_W'(W_MAX) :
			(hu_w < W_MIN) ? WORD_W'(W_MIN) : WORD_W'(hu_w);
		hv_s9   <= (hv_w > W_MAX) ? WORD_W'(W_MAX) :
			(hv_w < W_MIN) ? WORD_W'(W_MIN) : WORD_W'(hv_w);
		t_s9    <= t_s8;
		miss_s9 <= miss_s8;
		maxd_s9 <= ctx_s8.maxd;
	end

	// stage 10: edge products
	logic signed [PROD_W-1:0] p_a0_s10, p_a1_s10, p_b0_s10, p_b1_s10;
	logic signed [WORD_W-1:0] t_s10;
	logic                     miss_s10;
	logic [DIST_W-1:0]        maxd_s10;

	always_ff @(posedge clk) begin
		p_a0_s10 <= hv_s9 * bnu_q;
		p_a1_s10 <= hu_s9 * bnv_q;
		p_b0_s10 <= hu_s9 * cnu_q;
		p_b1_s10 <= hv_s9 * cnv_q;
		t_s10    <= t_s9;
		miss_s10 <= miss_s9;
		maxd_s10 <= maxd_s9;
	end

	// stage 11: barycentrics, inside test and result word
	logic signed [SUM_W-1:0] alpha, beta;
	logic signed [SUM_W:0]   ab_sum;
	logic                    is_hit;
	logic                    hit_s11;
	logic [DIST_W-1:0]       dist_s11;
	logic [BARY_W-1:0]       alpha_s11, beta_s11;

	localparam logic signed [SUM_W:0] ONE = (SUM_W+1)'(1) <<< FRAC_BITS;

	assign alpha  = SUM_W'(p_a0_s10 >>> FRAC_BITS) + SUM_W'(p_a1_s10 >>> FRAC_BITS);
	assign beta   = SUM_W'(p_b0_s10 >>> FRAC_BITS) + SUM_W'(p_b1_s10 >>> FRAC_BITS);
	assign ab_sum = (SUM_W+1)'(alpha) + (SUM_W+1)'(beta);
	assign is_hit = !miss_s10 && !alpha[SUM_W-1] && !beta[SUM_W-1] && (ab_sum <= ONE);

	always_ff @(posedge clk) begin
		hit_s11   <= is_hit;
		dist_s11  <= is_hit ? t_s10[DIST_W-1:0] : maxd_s10;
		alpha_s11 <= is_hit ? alpha[BARY_W-1:0] : '0;
		beta_s11  <= is_hit ? beta[BARY_W-1:0] : '0;
	end

	assign done       = vld_s11;
	assign hit        = hit_s11;
	assign hit_dist   = dist_s11;
	assign bary_alpha = alpha_s11;
	assign bary_beta  = beta_s11;

	// checks
	`ASSERT_IMP(a_fixed_latency, clk, arst_n, start && !busy, ##LATENCY done)
	`ASSERT_IMP(a_miss_clears_bary, clk, arst_n, done && !hit, bary_alpha == '0 && bary_beta == '0)
	`ASSERT_NXT(a_div_valid_moves, clk, arst_n, vld_s5, div_vld_s6[0])

endmodule

/* verif/tb_ray_triangle_intersect.sv */
// testbench for the ray/triangle intersection pipeline: random and directed rays
// checked against a bit-accurate fixed point predictor; depends on rti_pkg and the rtl
module tb_ray_triangle_intersect;
	import rti_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic        hit;
		logic [30:0] distance;
		logic [16:0] alpha;
		logic [16:0] beta;
	} isect_t;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic start, busy, done, hit;
	logic signed [WORD_W-1:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
	logic [DIST_W-1:0] max_dist, hit_dist;
	logic [BARY_W-1:0] bary_alpha, bary_beta;

	// shadow copy of the triangle registers
	logic [1:0]  tri_axis;
	logic [31:0] tri_nu, tri_nv, tri_nd;
	logic [63:0] tri_b, tri_c, tri_a;
	logic [15:0] tri_eps;

	isect_t pending_isect[$];
	int n_fail, n_words, n_hits, n_results;

	ray_triangle_intersect dut (.*);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("Simulation FAILED");
		$finish;
	end

	// fixed point product, floor shift
	function automatic longint fx_mul(longint a, longint b);
		return (a * b) >>> FRAC_BITS;
	endfunction

	function automatic longint sat_word(longint x);
		if (x > 64'sd2147483647) return 64'sd2147483647;
		if (x < -64'sd2147483648) return -64'sd2147483648;
		return x;
	endfunction

	// truncated saturated quotient with FRAC_BITS fraction bits
	function automatic longint fx_div(longint num, longint den);
		logic neg;
		logic [63:0] n, d, q, r, mag;
		neg = (num < 0) != (den < 0);
		n = num < 0 ? -num : num;
		d = den < 0 ? -den : den;
		q = n / d;
		r = n % d;
		if (q >= (64'd1 << (31 - FRAC_BITS))) mag = 64'h7FFFFFFF;
		else begin
			mag = q;
			for (int i = 0; i < FRAC_BITS; i++) begin
				r = r << 1;
				mag = mag << 1;
				if (r >= d) begin
					r = r - d;
					mag[0] = 1'b1;
				end
			end
			if (mag > 64'h7FFFFFFF) mag = 64'h7FFFFFFF;
		end
		return neg ? -longint'(mag) : longint'(mag);
	endfunction

	function automatic isect_t intersect_ray(logic [31:0] ox, oy, oz, dx, dy, dz,
		logic [30:0] maxd);
		isect_t res;
		longint o[3], d[3];
		longint nu, nv, num, den, t, hu, hv, al, be, lim;
		int k, ku, kv;
		o[0] = longint'(signed'(ox)); o[1] = longint'(signed'(oy));
		o[2] = longint'(signed'(oz));
		d[0] = longint'(signed'(dx)); d[1] = longint'(signed'(dy));
		d[2] = longint'(signed'(dz));
		nu = longint'(signed'(tri_nu));
		nv = longint'(signed'(tri_nv));
		k = (tri_axis > 2) ? 0 : tri_axis;
		ku = (k + 1) % 3;
		kv = (k + 2) % 3;
		res = '{1'b0, maxd, 17'd0, 17'd0};
		num = longint'(signed'(tri_nd)) - o[k] - fx_mul(nu, o[ku]) - fx_mul(nv, o[kv]);
		den = d[k] + fx_mul(nu, d[ku]) + fx_mul(nv, d[kv]);
		if (den == 0) return res;
		t = fx_div(num, den);
		lim = longint'(maxd) + longint'(tri_eps);
		if (t > lim || t < longint'(tri_eps)) return res;
		hu = sat_word(o[ku] + fx_mul(t, d[ku]) - longint'(signed'(tri_a[63:32])));
		hv = sat_word(o[kv] + fx_mul(t, d[kv]) - longint'(signed'(tri_a[31:0])));
		al = fx_mul(hv, longint'(signed'(tri_b[63:32])))
			+ fx_mul(hu, longint'(signed'(tri_b[31:0])));
		if (al < 0) return res;
		be = fx_mul(hu, longint'(signed'(tri_c[63:32])))
			+ fx_mul(hv, longint'(signed'(tri_c[31:0])));
		if (be < 0 || al + be > (64'sd1 << FRAC_BITS)) return res;
		res.hit = 1'b1;
		res.distance = t[30:0];
		res.alpha = al[16:0];
		res.beta = be[16:0];
		return res;
	endfunction

	// check each result word against the oldest prediction
	always @(posedge clk) begin
		isect_t want;
		if (arst_n && done) begin
			n_results++;
			if (pending_isect.size() == 0) begin
				n_fail++;
				$display("%0t: unexpected result word hit=%0b dist=%h", $realtime, hit,
					hit_dist);
			end else begin
				want = pending_isect.pop_front();
				if (hit !== want.hit || hit_dist !== want.distance
					|| bary_alpha !== want.alpha || bary_beta !== want.beta) begin
					n_fail++;
					$display("%0t: mismatch expected hit=%0b dist=%h a=%h b=%h",
						$realtime, want.hit, want.distance, want.alpha, want.beta);
					$display("%0t:          actual hit=%0b dist=%h a=%h b=%h",
						$realtime, hit, hit_dist, bary_alpha, bary_beta);
				end
				if (want.hit) n_hits++;
			end
		end
	end

	// start drops only when a gap is actually taken
	task automatic idle_gap();
		int g;
		g = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
		if ($urandom_range(0, 3) == 0) g = 0;
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// drive one ray word and record its prediction
	task automatic send_ray(logic [31:0] ox, oy, oz, dx, dy, dz, logic [30:0] maxd,
		bit gaps = 1);
		if (gaps) idle_gap();
		start <= 1'b1;
		origin_x <= ox; origin_y <= oy; origin_z <= oz;
		dir_x <= dx; dir_y <= dy; dir_z <= dz;
		max_dist <= maxd;
		@(posedge clk);
		while (busy) @(posedge clk);
		pending_isect.push_back(intersect_ray(ox, oy, oz, dx, dy, dz, maxd));
		n_words++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (pending_isect.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_AXIS:   tri_axis = val[1:0];
			REG_NU:     tri_nu = val[31:0];
			REG_NV:     tri_nv = val[31:0];
			REG_ND:     tri_nd = val[31:0];
			REG_EDGE_B: tri_b = val;
			REG_EDGE_C: tri_c = val;
			REG_VERT_A: tri_a = val;
			REG_EPS:    tri_eps = val[15:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	// unit right triangle in the plane perpendicular to the dominant axis at k=1
	task automatic load_flat_triangle(logic [1:0] axis, logic [15:0] eps);
		write_reg(REG_AXIS, axis);
		write_reg(REG_NU, 64'd0);
		write_reg(REG_NV, 64'd0);
		write_reg(REG_ND, 64'h10000);
		write_reg(REG_EDGE_B, {32'h10000, 32'h0});
		write_reg(REG_EDGE_C, {32'h10000, 32'h0});
		write_reg(REG_VERT_A, 64'd0);
		write_reg(REG_EPS, eps);
	endtask

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 32'h3FFFF) - 32'h1FFFF;
			default: return $urandom();
		endcase
	endfunction

	// pick a ray from the origin region that mostly hits the flat triangle
	task automatic send_aimed_ray(logic [1:0] axis, bit gaps);
		logic [31:0] c[3], v[3];
		int k;
		k = (axis > 2) ? 0 : axis;
		for (int i = 0; i < 3; i++) begin
			c[i] = $urandom_range(0, 32'h18000) - 32'h4000;
			v[i] = $urandom_range(0, 32'h8000) - 32'h4000;
		end
		c[k] = 32'h0;
		v[k] = $urandom_range(1, 32'h30000);
		if ($urandom_range(0, 7) == 0) v[k] = -v[k];
		send_ray(c[0], c[1], c[2], v[0], v[1], v[2],
			($urandom_range(0, 3) == 0) ? 31'($urandom()) : 31'($urandom_range(0, 32'h80000)),
			gaps);
	endtask

	task automatic test_directed_extremes();
		load_flat_triangle(AXIS_X, EPS_RESET);
		// plain hit, zero denominator, behind origin, past max distance within the slack
		send_ray(0, 32'h4000, 32'h4000, 32'h10000, 0, 0, 31'h7FFFFFFF);
		send_ray(0, 32'h4000, 32'h4000, 0, 32'h10000, 0, 31'h7FFFFFFF);
		send_ray(0, 32'h4000, 32'h4000, 32'hFFFF0000, 0, 0, 31'h7FFFFFFF);
		send_ray(0, 32'h4000, 32'h4000, 32'h10000, 0, 0, 31'h0FFFF);
		// tolerance slack at the far end, and quotient saturation
		send_ray(0, 32'h4000, 32'h4000, 32'h10000, 0, 0, 31'h0FFFA);
		send_ray(0, 32'h4000, 32'h4000, 32'h1, 0, 0, 31'h7FFFFFFF);
		send_ray(0, 32'h4000, 32'h4000, 32'hFFFFFFFF, 0, 0, 31'h7FFFFFFF);
		// vertices and edges, outside by alpha, beta and their sum
		send_ray(0, 0, 0, 32'h10000, 0, 0, 31'h7FFFFFFF);
		send_ray(0, 32'h10000, 0, 32'h10000, 0, 0, 31'h7FFFFFFF);
		send_ray(0, 0, 32'h10000, 32'h10000, 0, 0, 31'h7FFFFFFF);
		send_ray(0, 32'h8000, 32'h8000, 32'h10000, 0, 0, 31'h7FFFFFFF);
		send_ray(0, 32'hFFFFFFFF, 32'h4000, 32'h10000, 0, 0, 31'h7FFFFFFF);
		send_ray(0, 32'h4000, 32'hFFFFFFFF, 32'h10000, 0, 0, 31'h7FFFFFFF);
		send_ray(0, 32'h8001, 32'h8000, 32'h10000, 0, 0, 31'h7FFFFFFF);
		// field extremes, offsets that saturate
		send_ray(32'h80000000, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h80000000, 32'h80000000, 31'h0);
		send_ray(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF);
		send_ray(0, 32'h7FFFFFFF, 32'h80000000, 32'h10000, 32'h7FFFFFFF,
			32'h80000000, 31'h7FFFFFFF);
		drain();
		// unused axis code behaves as x, then y and z
		load_flat_triangle(2'd3, 16'd0);
		send_ray(0, 32'h4000, 32'h4000, 32'h10000, 0, 0, 31'h7FFFFFFF);
		drain();
		load_flat_triangle(AXIS_Y, 16'hFFFF);
		send_ray(32'h4000, 0, 32'h4000, 0, 32'h10000, 0, 31'h0);
		drain();
		load_flat_triangle(AXIS_Z, 16'd1);
		send_ray(32'h4000, 32'h4000, 0, 0, 0, 32'h10000, 31'h7FFFFFFF);
		drain();
	endtask

	// well-formed rays against flat triangles on each axis
	task automatic test_aimed_rays(int count);
		logic [1:0] ax;
		for (int p = 0; p < 4; p++) begin
			ax = 2'(p);
			load_flat_triangle(ax, (p == 1) ? 16'hFFFF : 16'($urandom_range(0, 64)));
			for (int i = 0; i < count / 4; i++) send_aimed_ray(ax, (i % 100) >= 30);
			drain();
		end
	endtask

	// random triangle coefficients and noisy rays
	task automatic test_random_triangles(int count);
		for (int p = 0; p < 6; p++) begin
			write_reg(REG_AXIS, 2'($urandom()));
			write_reg(REG_NU, $urandom_range(0, 32'h20000) - 32'h10000);
			write_reg(REG_NV, (p == 0) ? 64'h80000000 : $urandom_range(0, 32'h20000) - 32'h10000);
			write_reg(REG_ND, (p == 1) ? 64'h7FFFFFFF : rand_word());
			write_reg(REG_EDGE_B, {rand_word(), rand_word()});
			write_reg(REG_EDGE_C, {rand_word(), rand_word()});
			write_reg(REG_VERT_A, {rand_word(), rand_word()});
			write_reg(REG_EPS, 16'($urandom()));
			for (int i = 0; i < count / 6; i++)
				send_ray(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
					rand_word(), 31'($urandom()));
			drain();
		end
	endtask

	initial begin
		arst_n = 0;
		start = 0; cfg_we = 0; cfg_index = '0; cfg_wdata = '0;
		origin_x = 0; origin_y = 0; origin_z = 0;
		dir_x = 0; dir_y = 0; dir_z = 0; max_dist = 0;
		tri_axis = 0; tri_nu = 0; tri_nv = 0; tri_nd = 0;
		tri_b = 0; tri_c = 0; tri_a = 0; tri_eps = EPS_RESET;
		n_fail = 0; n_words = 0; n_hits = 0; n_results = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_aimed_rays(1400);
		test_random_triangles(540);
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		$display("%0d rays on four axis codes and random triangles, %0d results, %0d hits",
			n_words, n_results, n_hits);
		if (n_fail == 0 && pending_isect.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end
endmodule
